// File: rtl/core/siph_pkg.sv
package siph_pkg;

  // default graph size: edge index bits
  localparam int unsigned IndexBitsDefault = 29;

  // sipHash-2-4 schedule
  localparam int unsigned CRounds   = 2;
  localparam int unsigned DRounds   = 4;
  localparam int unsigned NumRounds = CRounds + DRounds;

  // finalization constant xored into lane v2
  localparam logic [63:0] FinalXor = 64'h0000_0000_0000_00ff;

  // rotation amounts of one round
  localparam int unsigned Rot13 = 13;
  localparam int unsigned Rot16 = 16;
  localparam int unsigned Rot17 = 17;
  localparam int unsigned Rot21 = 21;
  localparam int unsigned Rot32 = 32;

  // configuration port
  localparam int unsigned CfgAddrW = 8;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned NumKeys  = 4;

  typedef enum logic [CfgAddrW-1:0] {
    REG_KEY0 = 8'd0,
    REG_KEY1 = 8'd1,
    REG_KEY2 = 8'd2,
    REG_KEY3 = 8'd3
  } cfg_reg_e;

  // four 64-bit lanes v0..v3
  typedef logic [3:0][63:0] lanes_t;

  function automatic logic [63:0] rotl(logic [63:0] w, int unsigned n);
    return (w << n) | (w >> (64 - n));
  endfunction

  // one sipround over all four lanes
  function automatic lanes_t sip_round(lanes_t v);
    lanes_t r;
    r    = v;
    r[0] = r[0] + r[1];
    r[2] = r[2] + r[3];
    r[1] = rotl(r[1], Rot13);
    r[3] = rotl(r[3], Rot16);
    r[1] = r[1] ^ r[0];
    r[3] = r[3] ^ r[2];
    r[0] = rotl(r[0], Rot32);
    r[2] = r[2] + r[1];
    r[0] = r[0] + r[3];
    r[1] = rotl(r[1], Rot17);
    r[3] = rotl(r[3], Rot21);
    r[1] = r[1] ^ r[2];
    r[3] = r[3] ^ r[0];
    r[2] = rotl(r[2], Rot32);
    return r;
  endfunction

endpackage

// File: rtl/core/siphash24_edge_generator_core.sv
// Cuckoo Cycle edge generator: SipHash-2-4 of 2*index and 2*index+1.
// Channels:
//   cfg    - key writes; cfg_addr_i 0..3 selects key word 0..3, other
//            addresses are ignored; always ready. Write keys only while idle.
//   s_axis - one edge index per request in tdata.
//   m_axis - one result per request: node_first and node_second in tdata.
// Throughput: one edge per cycle unless m_axis stalls. Both hashes run side by side in a
// six-stage pipeline, one sipround per stage, plus an output register.
// Path: an accepted edge passes the six round stages, the first loaded at the
// accepting edge, then the output register that folds and masks the lanes and
// drives m_axis_tvalid.
// Reset: all stage valid bits and the output valid clear, keys become zero.
// Stall: when m_axis_tready is low the output holds, stages behind it fill
// up bubble by bubble, and s_axis_tready drops once every stage holds an
// item. Nothing is lost or repeated.
module siphash24_edge_generator_core #(
  parameter int unsigned INDEX_BITS = siph_pkg::IndexBitsDefault,
  localparam int unsigned NodeW = INDEX_BITS + 1,
  localparam int unsigned InW   = ((INDEX_BITS + 7) / 8) * 8,
  localparam int unsigned OutW  = ((2 * NodeW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [siph_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [siph_pkg::KeyW-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [InW-1:0]                s_axis_tdata,   // edge_index, zero pad
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutW-1:0]               m_axis_tdata    // node_first, node_second, zero pad
);

  localparam int unsigned NumSt = siph_pkg::NumRounds;

  // key registers
  logic [siph_pkg::NumKeys-1:0][siph_pkg::KeyW-1:0] key_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        siph_pkg::REG_KEY0: key_q[0] <= cfg_data_i;
        siph_pkg::REG_KEY1: key_q[1] <= cfg_data_i;
        siph_pkg::REG_KEY2: key_q[2] <= cfg_data_i;
        siph_pkg::REG_KEY3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // round stages: two hashes (even and odd word) per stage
  logic [NumSt-1:0]                      st_valid_q;
  logic [NumSt-2:0][INDEX_BITS-1:0]      st_idx_q;
  siph_pkg::lanes_t [NumSt-1:0][1:0]     st_lane_q;
  siph_pkg::lanes_t [NumSt-1:0][1:0]     st_lane_d;
  logic [NumSt-1:0]                      st_in_valid;
  logic [NumSt-1:0][INDEX_BITS-1:0]      st_in_idx;
  logic [NumSt:0]                        st_ready;

  logic                                  out_valid_q;
  logic [NodeW-1:0]                      node_first_q;
  logic [NodeW-1:0]                      node_second_q;
  logic [NodeW-1:0]                      node_first_d;
  logic [NodeW-1:0]                      node_second_d;

  // ready chain: a stage moves when empty or when the next one moves
  always_comb begin
    st_ready[NumSt] = !out_valid_q || m_axis_tready;
    for (int k = NumSt - 1; k >= 0; k--) begin
      st_ready[k] = !st_valid_q[k] || st_ready[k+1];
    end
  end

  assign s_axis_tready = st_ready[0];

  // next lanes of each stage
  always_comb begin
    siph_pkg::lanes_t src;
    logic [63:0]      word;
    for (int k = 0; k < NumSt; k++) begin
      if (k == 0) begin
        st_in_valid[k] = s_axis_tvalid;
        st_in_idx[k]   = s_axis_tdata[INDEX_BITS-1:0];
      end else begin
        st_in_valid[k] = st_valid_q[k-1];
        st_in_idx[k]   = st_idx_q[k-1];
      end
      for (int h = 0; h < 2; h++) begin
        word = 64'({st_in_idx[k], 1'b0}) | 64'(h);
        if (k == 0) begin
          src[0] = key_q[0];
          src[1] = key_q[1];
          src[2] = key_q[2];
          src[3] = key_q[3] ^ word;
        end else begin
          src = st_lane_q[k-1][h];
        end
        // message and finalization xor between compression and final rounds
        if (k == siph_pkg::CRounds) begin
          src[0] = src[0] ^ word;
          src[2] = src[2] ^ siph_pkg::FinalXor;
        end
        st_lane_d[k][h] = siph_pkg::sip_round(src);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else begin
      for (int k = 0; k < NumSt; k++) begin
        if (st_ready[k]) begin
          st_valid_q[k] <= st_in_valid[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumSt; k++) begin
      if (st_ready[k] && st_in_valid[k]) begin
        st_lane_q[k] <= st_lane_d[k];
      end
    end
    // the index travels only as far as the last stage that reads it
    for (int k = 0; k < NumSt - 1; k++) begin
      if (st_ready[k] && st_in_valid[k]) begin
        st_idx_q[k] <= st_in_idx[k];
      end
    end
  end

  // fold lanes and mask to node bits
  always_comb begin
    logic [63:0] h0;
    logic [63:0] h1;
    h0 = st_lane_q[NumSt-1][0][0] ^ st_lane_q[NumSt-1][0][1] ^
         st_lane_q[NumSt-1][0][2] ^ st_lane_q[NumSt-1][0][3];
    h1 = st_lane_q[NumSt-1][1][0] ^ st_lane_q[NumSt-1][1][1] ^
         st_lane_q[NumSt-1][1][2] ^ st_lane_q[NumSt-1][1][3];
    node_first_d  = h0[NodeW-1:0];
    node_second_d = {h1[NodeW-1:1], 1'b1};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_ready[NumSt]) begin
      out_valid_q <= st_valid_q[NumSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_ready[NumSt] && st_valid_q[NumSt-1]) begin
      node_first_q  <= node_first_d;
      node_second_q <= node_second_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({node_second_q, node_first_q});

  // input stalls only when every stage and the output are occupied
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&st_valid_q)))
    else $error("input stalled with a free pipeline slot");

  // second endpoint is always odd
  a_second_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[NodeW])
    else $error("node_second lowest bit not set");

  // an item in the last stage reaches the output when the output frees up
  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid_q[NumSt-1] && (!out_valid_q || m_axis_tready)) |=> out_valid_q)
    else $error("last stage item not delivered to output register");

endmodule

// File: sim/edge_gen_checker.sv
module edge_gen_checker #(
  parameter int unsigned IndexBits = siph_pkg::IndexBitsDefault,
  localparam int unsigned NodeW = IndexBits + 1,
  localparam int unsigned InW   = ((IndexBits + 7) / 8) * 8,
  localparam int unsigned OutW  = ((2 * NodeW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // key write channel
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [siph_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [siph_pkg::KeyW-1:0]     cfg_data_i,
  // edge index stream
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [InW-1:0]                in_data_i,   // edge_index, zero pad
  // endpoint stream
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [OutW-1:0]               out_data_i,  // node_first, node_second, zero pad
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NodeW-1:0] node_first;
    logic [NodeW-1:0] node_second;
  } endpoints_t;

  logic [siph_pkg::KeyW-1:0] key_q [siph_pkg::NumKeys];
  endpoints_t                endpoint_q [$];
  endpoints_t                want;
  logic [NodeW-1:0]          got_first;
  logic [NodeW-1:0]          got_second;
  logic [OutW-1:0]           got_pad;
  int unsigned               fails;

  function automatic logic [63:0] rotl64(input logic [63:0] w, input int unsigned n);
    return (w << n) | (w >> (64 - n));
  endfunction

  // sipHash-2-4 of a single 64-bit word under the current keys
  function automatic logic [63:0] sip_hash(input logic [63:0] word);
    logic [63:0] v0, v1, v2, v3;
    int unsigned r;
    v0 = key_q[0];
    v1 = key_q[1];
    v2 = key_q[2];
    v3 = key_q[3] ^ word;
    for (r = 0; r < siph_pkg::NumRounds; r++) begin
      // message absorb and finalization between compression and final rounds
      if (r == siph_pkg::CRounds) begin
        v0 = v0 ^ word;
        v2 = v2 ^ siph_pkg::FinalXor;
      end
      v0 = v0 + v1;
      v2 = v2 + v3;
      v1 = rotl64(v1, 13) ^ v0;
      v3 = rotl64(v3, 16) ^ v2;
      v0 = rotl64(v0, 32);
      v2 = v2 + v1;
      v0 = v0 + v3;
      v1 = rotl64(v1, 17) ^ v2;
      v3 = rotl64(v3, 21) ^ v0;
      v2 = rotl64(v2, 32);
    end
    return v0 ^ v1 ^ v2 ^ v3;
  endfunction

  // both endpoints of one edge
  function automatic endpoints_t edge_endpoints(input logic [IndexBits-1:0] idx);
    endpoints_t e;
    logic [63:0] even_word;
    even_word = 64'(idx) << 1;
    e.node_first  = NodeW'(sip_hash(even_word));
    e.node_second = NodeW'(sip_hash(even_word | 64'd1)) | NodeW'(1);
    return e;
  endfunction

  task automatic note_fail(input string what, input logic [63:0] exp_v,
                           input logic [63:0] act_v);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (key_q[k]) key_q[k] = '0;
      endpoint_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // key writes, unknown addresses dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          siph_pkg::REG_KEY0: key_q[0] = cfg_data_i;
          siph_pkg::REG_KEY1: key_q[1] = cfg_data_i;
          siph_pkg::REG_KEY2: key_q[2] = cfg_data_i;
          siph_pkg::REG_KEY3: key_q[3] = cfg_data_i;
          default: ;
        endcase
      end
      // compare a delivered edge with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got_first  = out_data_i[NodeW-1:0];
        got_second = out_data_i[2*NodeW-1:NodeW];
        got_pad    = out_data_i >> (2 * NodeW);
        if (endpoint_q.size() == 0) begin
          note_fail("unexpected result", '0, 64'(out_data_i));
        end else begin
          want = endpoint_q.pop_front();
          if (got_first !== want.node_first) begin
            note_fail("node_first", 64'(want.node_first), 64'(got_first));
          end
          if (got_second !== want.node_second) begin
            note_fail("node_second", 64'(want.node_second), 64'(got_second));
          end
          if (got_pad !== '0) begin
            note_fail("tdata padding", '0, 64'(got_pad));
          end
        end
      end
      // predict a newly accepted edge index
      if (in_valid_i && in_ready_i) begin
        endpoint_q = {endpoint_q, edge_endpoints(in_data_i[IndexBits-1:0])};
      end
      fail_count_o <= fails;
      pending_o    <= endpoint_q.size();
    end
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IndexBits  = siph_pkg::IndexBitsDefault;
  localparam int unsigned NodeW      = IndexBits + 1;
  localparam int unsigned InW        = ((IndexBits + 7) / 8) * 8;
  localparam int unsigned OutW       = ((2 * NodeW + 7) / 8) * 8;
  localparam int unsigned IdlePct    = 18;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned WatchLimit = 3000;
  localparam int unsigned PhaseEdges = 300;
  localparam int unsigned NumPhases  = 6;
  localparam logic [IndexBits-1:0] IndexMax = '1;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [siph_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [siph_pkg::KeyW-1:0]     cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [InW-1:0]                s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [OutW-1:0]               m_tdata;
  int unsigned                   fail_count;
  int unsigned                   pending;

  // stimulus controls shared with the receiver
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned stall_cycles = 0;
  int unsigned backpressure_cycles = 0;
  int unsigned edges_sent = 0;
  int unsigned key_loads = 0;

  siph_pkg::cfg_reg_e key_reg [siph_pkg::NumKeys] =
    '{siph_pkg::REG_KEY0, siph_pkg::REG_KEY1, siph_pkg::REG_KEY2, siph_pkg::REG_KEY3};

  siphash24_edge_generator_core #(
    .INDEX_BITS(IndexBits)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  edge_gen_checker #(
    .IndexBits(IndexBits)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog on cycles with no request accepted anywhere
  always @(posedge clk) begin
    if (s_tvalid && !s_tready) begin
      backpressure_cycles <= backpressure_cycles + 1;
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchLimit) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d results outstanding",
               WatchLimit, pending);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result receiver: random idling, quiet stretches, one long hold-off
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end
      m_tready <= rx_quiet || ($urandom_range(99) >= IdlePct);
    end
  end

  // offer one edge index and wait for its request to be taken
  task automatic offer_edge(input logic [IndexBits-1:0] idx);
    if (!tx_quiet && $urandom_range(99) < IdlePct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InW'(idx);
    do @(posedge clk); while (!s_tready);
    edges_sent++;
  endtask

  // stop offering and wait until every predicted edge has come out
  task automatic drain_edges();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // write all four keys, with one write to an unmapped address mixed in
  task automatic load_keys(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
    logic [63:0] vals [siph_pkg::NumKeys];
    int unsigned stray_slot;
    int unsigned n;
    int unsigned slot;
    vals = '{k0, k1, k2, k3};
    stray_slot = $urandom_range(siph_pkg::NumKeys);
    for (n = 0; n <= siph_pkg::NumKeys; n++) begin
      cfg_valid <= 1'b1;
      if (n == stray_slot) begin
        cfg_addr <= siph_pkg::CfgAddrW'($urandom_range(siph_pkg::NumKeys,
                                                       (1 << siph_pkg::CfgAddrW) - 1));
        cfg_data <= {$urandom, $urandom};
      end else begin
        slot = (n > stray_slot) ? n - 1 : n;
        cfg_addr <= key_reg[slot];
        cfg_data <= vals[slot];
      end
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    key_loads++;
  endtask

  // random index, biased toward the ends of the range
  function automatic logic [IndexBits-1:0] rand_edge();
    case ($urandom_range(9))
      0: return IndexMax;
      1: return '0;
      2: return IndexBits'(1) << $urandom_range(IndexBits - 1);
      default: return IndexBits'($urandom);
    endcase
  endfunction

  task automatic run_directed();
    logic [IndexBits-1:0] picks [12];
    picks = '{'0, IndexBits'(1), IndexBits'(2), IndexBits'(3), IndexMax,
              IndexMax - IndexBits'(1),
              IndexBits'(1) << (IndexBits - 1),
              (IndexBits'(1) << (IndexBits - 1)) - IndexBits'(1),
              IndexBits'({(IndexBits+1)/2{2'b01}}), IndexBits'({(IndexBits+1)/2{2'b10}}),
              IndexBits'(32'h0012_3456), IndexBits'($urandom)};
    foreach (picks[i]) offer_edge(picks[i]);
    drain_edges();
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed edges under reset keys, then under all-ones keys
    run_directed();
    load_keys('1, '1, '1, '1);
    run_directed();

    // random phases, one key setting each
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        1:       load_keys({32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}});
        3:       load_keys('0, '0, '0, '0);
        default: load_keys({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      tx_quiet = (phase == 2);
      rx_quiet = (phase == 2);
      // long output hold while the input keeps offering
      if (phase == 4) begin
        hold_reqs++;
        tx_quiet = 1'b1;
      end
      for (n = 0; n < PhaseEdges; n++) begin
        offer_edge(rand_edge());
        if (phase == 4 && n == 40) tx_quiet = 1'b0;
      end
      drain_edges();
    end

    repeat (12) @(posedge clk);
    $display("covered %0d edges under %0d key loads plus reset keys, extremes and stray writes",
             edges_sent, key_loads);
    $display("random idling on both streams, %0d cycles of input backpressure, drains per phase",
             backpressure_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/siph_pkg.sv
rtl/core/siphash24_edge_generator_core.sv
sim/edge_gen_checker.sv
sim/tb_top.sv
